// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property: expr must hold at every clock edge out of reset.
`define PSS_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pss check failed");

// Next-cycle property: when ante holds, cons must hold at the next clock edge.
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pss check failed");

`endif

// ===== src/pss_pkg.sv =====
// Shared types and constants of the job scheduler.
package pss_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int BURST_BITS = 16;
    localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_RAW    = $clog2(NUM_SLOTS + 1);
    localparam int CNT_BITS   = (CNT_RAW > 5) ? CNT_RAW : 5;
    localparam int TICK_BITS  = (BURST_BITS > 16) ? BURST_BITS : 16;
    localparam int TIME_BITS  = 20;
    localparam int SUM_BITS   = ((TICK_BITS > TIME_BITS) ? TICK_BITS : TIME_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_RR   = 2'd0;
    localparam t_mode MODE_PRIO = 2'd1;
    localparam t_mode MODE_SJF  = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MODE    = 2'd0;
    localparam t_reg_idx REG_QUANTUM = 2'd1;
    localparam t_reg_idx REG_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [3:0]  slot;
        logic [15:0] load_burst;
        logic [7:0]  load_priority;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  ran_slot;
        logic [15:0] ran_ticks;
        logic [19:0] finish_time;
        logic        job_done;
        logic        all_done;
    } t_out_item;

    // Contents of one slot cell.
    typedef struct packed {
        logic [BURST_BITS-1:0] burst;
        logic [7:0]            prio;
    } t_cell;

    // Scan control from the sequencer to the pick unit.
    typedef struct packed {
        logic                 clear;
        logic                 step;
        t_mode                mode;
        logic [SLOT_BITS-1:0] start;
        logic [SLOT_BITS-1:0] idx;
        logic [CNT_BITS-1:0]  n_use;
    } t_scan_ctl;

    // Decision handed back by the pick unit.
    typedef struct packed {
        logic                  found;
        logic [SLOT_BITS-1:0]  pick;
        logic [BURST_BITS-1:0] burst;
    } t_sel;

endpackage

// ===== src/pss_cell.sv =====
// One slot cell of the job ring: holds burst and priority, shifts to its neighbor.
module pss_cell import pss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  t_cell                 i_next,
    input  logic                  i_load,
    input  t_cell                 i_load_data,
    input  logic                  i_sub,
    input  logic [BURST_BITS-1:0] i_sub_ticks,
    output t_cell                 o_cell
);

    t_cell r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_load) begin
            r_cell <= i_load_data;
        end else if (i_shift) begin
            r_cell <= i_next;
        end else if (i_sub) begin
            r_cell.burst <= r_cell.burst - i_sub_ticks;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== src/pss_pick.sv =====
// Pick unit: watches the ring head one slot per cycle and keeps the best candidate.
module pss_pick import pss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_cell     i_head,
    output t_sel      o_sel
);

    logic                  r_found;
    logic [SLOT_BITS-1:0]  r_pick;
    logic [BURST_BITS-1:0] r_burst;
    logic [7:0]            r_prio;
    // first live slot at or after the rotation start (round robin only)
    logic                  r_hfound;
    logic [SLOT_BITS-1:0]  r_hpick;
    logic [BURST_BITS-1:0] r_hburst;

    logic live;
    logic is_rr;
    logic take_main;
    logic take_hi;

    always_comb begin
        live  = (CNT_BITS'(i_ctl.idx) < i_ctl.n_use) && (i_head.burst != '0);
        is_rr = (i_ctl.mode != MODE_PRIO) && (i_ctl.mode != MODE_SJF);
        unique case (i_ctl.mode)
            MODE_PRIO: take_main = live && (!r_found || i_head.prio > r_prio);
            MODE_SJF:  take_main = live && (!r_found || i_head.burst < r_burst);
            default:   take_main = live && !r_found;
        endcase
        take_hi = is_rr && live && !r_hfound && (i_ctl.idx >= i_ctl.start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_hfound <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found  <= 1'b0;
            r_hfound <= 1'b0;
        end else if (i_ctl.step) begin
            if (take_main) r_found  <= 1'b1;
            if (take_hi)   r_hfound <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && take_main) begin
            r_pick  <= i_ctl.idx;
            r_burst <= i_head.burst;
            r_prio  <= i_head.prio;
        end
        if (i_ctl.step && take_hi) begin
            r_hpick  <= i_ctl.idx;
            r_hburst <= i_head.burst;
        end
    end

    // Round robin wraps to the first live slot when none sits at or after the start.
    always_comb begin
        if (r_hfound) begin
            o_sel.found = 1'b1;
            o_sel.pick  = r_hpick;
            o_sel.burst = r_hburst;
        end else begin
            o_sel.found = r_found;
            o_sel.pick  = r_pick;
            o_sel.burst = r_burst;
        end
    end

endmodule

// ===== src/process_scheduler_rr_prio_sjf.sv =====
// Top level of the job scheduler: slot ring, scan sequencer, decision and result.
// Step beat: accepted with start; ST_SCAN turns the slot ring once past the pick unit,
// one slot per cycle, ST_FIN applies the decision, and the result strobe is registered.
// Busy holds off new items meanwhile; a new item may start the cycle the strobe shows.
// Load beat: no result, busy never rises. The receiver cannot stall.
// Reset (synchronous, active low) clears all slots, time, pointer and config to defaults.
module process_scheduler_rr_prio_sjf import pss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_valid,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  t_reg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    t_mode       r_mode;
    logic [15:0] r_quantum;
    logic [4:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RR;
            r_quantum <= 16'd1;
            r_count   <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[1:0];
                REG_QUANTUM: r_quantum <= i_cfg_data;
                REG_COUNT:   r_count   <= i_cfg_data[4:0];
                default:     ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- sequencer ----------------
    t_state               r_state, n_state;
    logic [SLOT_BITS-1:0] r_idx, n_idx;
    logic                 accept;
    logic                 acc_load;
    logic                 acc_step;
    logic                 shift;
    logic                 fin;

    assign accept   = start && !busy;
    assign acc_load = accept && (i_item.operation == OP_LOAD);
    assign acc_step = accept && (i_item.operation == OP_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        busy    = 1'b0;
        shift   = 1'b0;
        fin     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_step) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                busy  = 1'b1;
                shift = 1'b1;
                n_idx = r_idx + 1'b1;
                // ring is back in place after NUM_SLOTS shifts
                if (r_idx == SLOT_BITS'(NUM_SLOTS - 1)) begin
                    n_state = ST_FIN;
                    n_idx   = '0;
                end
            end
            ST_FIN: begin
                busy    = 1'b1;
                fin     = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- schedule state ----------------
    logic [TIME_BITS-1:0] r_time;
    logic [SLOT_BITS-1:0] r_ptr;
    logic [CNT_BITS-1:0]  n_use;
    logic [SLOT_BITS-1:0] start_slot;

    // count above the table size uses the whole table
    assign n_use = (CNT_BITS'(r_count) > CNT_BITS'(NUM_SLOTS)) ?
                   CNT_BITS'(NUM_SLOTS) : CNT_BITS'(r_count);
    // stale pointer past the slots in use restarts at slot zero
    assign start_slot = (CNT_BITS'(r_ptr) < n_use) ? r_ptr : '0;

    // ---------------- slot ring ----------------
    t_cell                 cells [NUM_SLOTS];
    t_cell                 load_data;
    t_sel                  sel;
    logic [TICK_BITS-1:0]  ticks;
    logic [BURST_BITS-1:0] sub_ticks;

    assign load_data.burst = BURST_BITS'(i_item.load_burst);
    assign load_data.prio  = i_item.load_priority;
    assign sub_ticks       = BURST_BITS'(ticks);

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        // slot k+1 hands its contents down; the head wraps to the tail
        pss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (shift),
            .i_next      (cells[(k + 1) % NUM_SLOTS]),
            .i_load      (acc_load && (32'(i_item.slot) == k)),
            .i_load_data (load_data),
            .i_sub       (fin && sel.found && (sel.pick == SLOT_BITS'(k))),
            .i_sub_ticks (sub_ticks),
            .o_cell      (cells[k])
        );
    end

    // ---------------- pick unit ----------------
    t_scan_ctl ctl;

    always_comb begin
        ctl.clear = acc_step;
        ctl.step  = shift;
        ctl.mode  = r_mode;
        ctl.start = start_slot;
        ctl.idx   = r_idx;
        ctl.n_use = n_use;
    end

    pss_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_head  (cells[0]),
        .o_sel   (sel)
    );

    // ---------------- decision and result ----------------
    logic                  is_rr;
    logic [15:0]           quantum;
    logic [BURST_BITS-1:0] left;
    logic [SUM_BITS-1:0]   sum;
    logic [TIME_BITS-1:0]  time_next;
    logic [CNT_BITS-1:0]   pick_inc;

    always_comb begin
        is_rr   = (r_mode != MODE_PRIO) && (r_mode != MODE_SJF);
        quantum = (r_quantum == '0) ? 16'd1 : r_quantum;  // zero quantum acts as one
        if (is_rr) begin
            ticks = (TICK_BITS'(sel.burst) < TICK_BITS'(quantum)) ?
                    TICK_BITS'(sel.burst) : TICK_BITS'(quantum);
        end else begin
            ticks = TICK_BITS'(1);
        end
        left      = sel.burst - sub_ticks;
        sum       = SUM_BITS'(r_time) + SUM_BITS'(ticks);
        time_next = (sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);
        pick_inc  = CNT_BITS'(sel.pick) + CNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_ptr  <= '0;
        end else if (acc_load) begin
            r_time <= '0;
            r_ptr  <= '0;
        end else if (fin && sel.found) begin
            r_time <= time_next;
            if (is_rr) begin
                r_ptr <= (pick_inc >= n_use) ? '0 : SLOT_BITS'(pick_inc);
            end
        end
    end

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            if (sel.found) begin
                o_result.ran_slot    <= 4'(sel.pick);
                o_result.ran_ticks   <= 16'(ticks);
                o_result.finish_time <= time_next;
                o_result.job_done    <= (left == '0);
                o_result.all_done    <= 1'b0;
            end else begin
                // nothing live: idle report at unchanged time
                o_result.ran_slot    <= '0;
                o_result.ran_ticks   <= '0;
                o_result.finish_time <= r_time;
                o_result.job_done    <= 1'b0;
                o_result.all_done    <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== src/pss_checker.sv =====
// Port-level checker for the job scheduler, bound to the top level.
`include "assert_macros.svh"

module pss_checker import pss_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input t_in_item    i_item,
    input logic        o_valid,
    input t_out_item   o_result,
    input logic        i_cfg_we,
    input t_reg_idx    i_cfg_idx,
    input logic [15:0] i_cfg_data
);

    `PSS_ASSERT_NEXT(a_step_busy, i_clk, i_rst_n, start && !busy && i_item.operation == OP_STEP, busy)
    `PSS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `PSS_ASSERT(a_strobe_idle, i_clk, i_rst_n, !o_valid || !busy)
    `PSS_ASSERT(a_idle_report, i_clk, i_rst_n, !(o_valid && o_result.all_done) || (o_result.ran_ticks == '0 && !o_result.job_done && o_result.ran_slot == '0))
    `PSS_ASSERT(a_run_ticks, i_clk, i_rst_n, !(o_valid && !o_result.all_done) || o_result.ran_ticks != '0)

endmodule

bind process_scheduler_rr_prio_sjf pss_checker u_pss_checker (.*);

// ===== verif/process_scheduler_rr_prio_sjf_tb.sv =====
// Self-checking testbench for the round-robin / priority / shortest-first job scheduler.
`timescale 1ns / 1ps

module process_scheduler_rr_prio_sjf_tb;
    import pss_pkg::*;

    // Register value 3 is not a named policy; the block treats it as round robin.
    localparam t_mode MODE_RR_ALIAS = 2'd3;
    // Quiet time after the last strobe before a register write or the final verdict.
    localparam int SETTLE_CYCLES = NUM_SLOTS + 4;
    localparam int RANDOM_BEATS  = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_valid;
    t_out_item   o_result;
    logic        i_cfg_we = 1'b0;
    t_reg_idx    i_cfg_idx = REG_MODE;
    logic [15:0] i_cfg_data = '0;

    // Scheduler mirror: slot table, clock and rotation, plus register copies.
    bit [15:0]        slot_burst [NUM_SLOTS];
    bit [7:0]         slot_prio  [NUM_SLOTS];
    bit [TIME_BITS-1:0] sched_time = '0;
    int               rr_next = 0;
    t_mode            cur_mode = MODE_RR;
    bit [15:0]        cur_quantum = 16'd1;
    bit [4:0]         cur_count = 5'd1;

    // Decisions predicted at accept time, oldest first.
    t_out_item        pending_results [$];
    int               mismatch_count = 0;
    int               beats_sent = 0;
    int               sender_run = 0;

    process_scheduler_rr_prio_sjf DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decision predictor. A load rewrites one slot and restarts the
    // schedule (time and rotation back to zero) with no result; a step
    // picks a slot by the current policy and always yields one result.
    // ------------------------------------------------------------------
    function automatic void predict_decision(input t_in_item it, output bit gives,
                                             output t_out_item res);
        int n;
        int pick;
        int ticks;
        int s;
        int start_at;
        bit found;
        bit [15:0] q;

        res = '0;
        gives = 1'b0;
        n = (cur_count > NUM_SLOTS) ? NUM_SLOTS : int'(cur_count);

        if (it.operation == OP_LOAD) begin
            if (it.slot < NUM_SLOTS) begin
                slot_burst[it.slot] = it.load_burst;
                slot_prio[it.slot]  = it.load_priority;
            end
            sched_time = '0;
            rr_next = 0;
            return;
        end

        gives = 1'b1;
        found = 1'b0;
        pick = 0;
        ticks = 0;
        case (cur_mode)
            MODE_PRIO: begin
                // Strict greater-than keeps the lowest slot on a tie.
                for (int i = 0; i < n; i++) begin
                    if (slot_burst[i] != 0 && (!found || slot_prio[i] > slot_prio[pick])) begin
                        pick = i;
                        found = 1'b1;
                    end
                end
                ticks = 1;
            end
            MODE_SJF: begin
                for (int i = 0; i < n; i++) begin
                    if (slot_burst[i] != 0 && (!found || slot_burst[i] < slot_burst[pick])) begin
                        pick = i;
                        found = 1'b1;
                    end
                end
                ticks = 1;
            end
            default: begin
                // Round robin, also for the unnamed mode value. A stale
                // pointer past the slots in use restarts the search at 0.
                start_at = (rr_next < n) ? rr_next : 0;
                q = (cur_quantum == 0) ? 16'd1 : cur_quantum;
                for (int i = 0; i < n; i++) begin
                    s = start_at + i;
                    if (s >= n) s -= n;
                    if (!found && slot_burst[s] != 0) begin
                        pick = s;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    ticks = (slot_burst[pick] < q) ? int'(slot_burst[pick]) : int'(q);
                    rr_next = (pick + 1 >= n) ? 0 : pick + 1;
                end
            end
        endcase

        if (!found) begin
            res.finish_time = sched_time;
            res.all_done = 1'b1;
            return;
        end

        slot_burst[pick] = slot_burst[pick] - 16'(ticks);
        if (ticks > int'(TIME_MAX - sched_time))
            sched_time = TIME_MAX;
        else
            sched_time = sched_time + TIME_BITS'(ticks);

        res.ran_slot    = 4'(pick);
        res.ran_ticks   = 16'(ticks);
        res.finish_time = sched_time;
        res.job_done    = (slot_burst[pick] == 0);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is a beat that must match the oldest
    // prediction. Values are sampled before the edge updates them.
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string what, input t_out_item want, input t_out_item got);
        if (mismatch_count < 10)
            $display("%0t MISMATCH %s: exp s%0d t%0d f%0d d%0b a%0b | got s%0d t%0d f%0d d%0b a%0b",
                     $realtime, what, want.ran_slot, want.ran_ticks, want.finish_time,
                     want.job_done, want.all_done, got.ran_slot, got.ran_ticks,
                     got.finish_time, got.job_done, got.all_done);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result", '0, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_valid !== 1'b1 ||
                    o_result.ran_slot    !== want.ran_slot    ||
                    o_result.ran_ticks   !== want.ran_ticks   ||
                    o_result.finish_time !== want.finish_time ||
                    o_result.job_done    !== want.job_done    ||
                    o_result.all_done    !== want.all_done)
                    log_mismatch("field", want, o_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One beat: hold start until an edge sees busy low, then predict.
    // start is left high so a following beat can go back to back.
    task automatic drive_beat(input t_in_item it);
        bit gives;
        t_out_item res;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_decision(it, gives, res);
        if (gives) pending_results.push_back(res);
        beats_sent++;
    endtask

    // Bursts of random length; between bursts a gap of random length,
    // sometimes none, so gaps land on every cycle of a decision.
    task automatic pace_sender();
        int gap;
        if (sender_run == 0) begin
            sender_run = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        sender_run--;
    endtask

    task automatic load_slot(input logic [3:0] s, input logic [15:0] b, input logic [7:0] p);
        t_in_item it;
        it.operation     = OP_LOAD;
        it.slot          = s;
        it.load_burst    = b;
        it.load_priority = p;
        pace_sender();
        drive_beat(it);
    endtask

    // Step beats carry random junk in the load fields; the block ignores it.
    task automatic step_once();
        t_in_item it;
        it = t_in_item'($urandom);
        it.operation = OP_STEP;
        pace_sender();
        drive_beat(it);
    endtask

    // Drain: every predicted result back, then the settle quiet time.
    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges. With noisy set the
    // unused upper data bits are random; the block keeps only the low bits.
    task automatic write_config(input t_mode m, input logic [15:0] qv, input logic [4:0] cv,
                                input bit noisy);
        logic [15:0] mode_data;
        logic [15:0] count_data;
        mode_data  = noisy ? 16'($urandom) : 16'd0;
        count_data = noisy ? 16'($urandom) : 16'd0;
        mode_data[1:0]  = m;
        count_data[4:0] = cv;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MODE;
        i_cfg_data <= mode_data;
        @(posedge i_clk);
        cur_mode = mode_data[1:0];
        i_cfg_idx  <= REG_QUANTUM;
        i_cfg_data <= qv;
        @(posedge i_clk);
        cur_quantum = qv;
        i_cfg_idx  <= REG_COUNT;
        i_cfg_data <= count_data;
        @(posedge i_clk);
        cur_count = count_data[4:0];
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_burst();
        case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 10));
        endcase
    endfunction

    // Small priorities often, to force ties.
    function automatic logic [7:0] pick_prio();
        case ($urandom_range(0, 7))
            0:          return 8'hFF;
            1:          return 8'h00;
            2, 3, 4:    return 8'($urandom_range(0, 3));
            default:    return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Empty table right after reset, then no slots in use at all.
    task automatic test_nothing_live();
        step_once();
        settle();
        write_config(MODE_RR, 16'd1, 5'd0, 1'b0);
        load_slot(4'd0, 16'd5, 8'd9);
        step_once();
    endtask

    // Quantum 3 over three slots, one of them loaded as already finished.
    task automatic test_round_robin();
        settle();
        write_config(MODE_RR, 16'd3, 5'd3, 1'b0);
        load_slot(4'd0, 16'd4, 8'd0);
        load_slot(4'd1, 16'd0, 8'd200);
        load_slot(4'd2, 16'd2, 8'd1);
        repeat (4) step_once();
    endtask

    // Unnamed mode value and a zero quantum: one-tick round robin.
    task automatic test_quantum_zero();
        settle();
        write_config(MODE_RR_ALIAS, 16'd0, 5'd2, 1'b0);
        load_slot(4'd1, 16'd2, 8'd7);
        repeat (2) step_once();
    endtask

    // Count above the table size; equal top priorities, lowest slot wins.
    task automatic test_priority();
        settle();
        write_config(MODE_PRIO, 16'hFFFF, 5'd17, 1'b0);
        load_slot(4'd15, 16'hFFFF, 8'hFF);
        load_slot(4'd3, 16'd1, 8'hFF);
        repeat (2) step_once();
    endtask

    // Largest count value; equal shortest bursts, lowest slot wins.
    task automatic test_shortest();
        settle();
        write_config(MODE_SJF, 16'hFFFF, 5'd31, 1'b0);
        load_slot(4'd4, 16'd2, 8'd0);
        load_slot(4'd5, 16'd2, 8'd128);
        repeat (3) step_once();
    endtask

    // Rotation left at slot 3, then the count shrinks to 2: search from 0.
    task automatic test_pointer_outside();
        settle();
        write_config(MODE_RR, 16'd1, 5'd4, 1'b0);
        load_slot(4'd0, 16'd2, 8'd0);
        load_slot(4'd1, 16'd2, 8'd0);
        load_slot(4'd2, 16'd2, 8'd0);
        repeat (3) step_once();
        settle();
        write_config(MODE_RR, 16'd1, 5'd2, 1'b0);
        step_once();
    endtask

    // ------------------------------------------------------------------
    // Random phases: a fresh register setting, mostly a random load of
    // the slots in use and of some others, then a run of steps with the
    // odd stray load mixed in.
    task automatic test_random_mix();
        int target;
        int n_use;
        t_mode m;
        logic [15:0] qv;
        logic [4:0] cv;

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            settle();
            m = t_mode'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       qv = 16'd0;
                1:       qv = 16'd1;
                2:       qv = 16'hFFFF;
                3:       qv = 16'($urandom);
                default: qv = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       cv = 5'd0;
                1:       cv = 5'($urandom_range(17, 31));
                2:       cv = 5'd16;
                default: cv = 5'($urandom_range(1, 16));
            endcase
            write_config(m, qv, cv, $urandom_range(0, 7) == 0);
            n_use = (cv > NUM_SLOTS) ? NUM_SLOTS : int'(cv);

            // Now and then keep the old table to run on leftover state.
            if ($urandom_range(0, 5) != 0) begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (s < n_use || $urandom_range(0, 7) == 0)
                        load_slot(4'(s), pick_burst(), pick_prio());
                end
            end

            repeat ($urandom_range(4, 40)) begin
                if ($urandom_range(0, 11) == 0)
                    load_slot(4'($urandom), pick_burst(), pick_prio());
                else
                    step_once();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_nothing_live();
        test_round_robin();
        test_quantum_zero();
        test_priority();
        test_shortest();
        test_pointer_outside();
        test_random_mix();

        start <= 1'b0;
        for (int k = 0; k < 5000 && pending_results.size() != 0; k++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
